// ===== design/m3i_pkg.sv =====
package m3i_pkg;

    localparam int unsigned NUM_ELEMS = 9;

    typedef logic [3:0] idx_t;

    // cofactor k = a[PROD_A_IDX] * a[PROD_B_IDX] - a[SUBT_A_IDX] * a[SUBT_B_IDX]
    // elements and adjugate entries (transposed cofactors) are indexed row-major (row * 3 + column)
    localparam idx_t PROD_A_IDX [NUM_ELEMS] =
        '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam idx_t PROD_B_IDX [NUM_ELEMS] =
        '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam idx_t SUBT_A_IDX [NUM_ELEMS] =
        '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam idx_t SUBT_B_IDX [NUM_ELEMS] =
        '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // cofactors that pair with row 0 in the determinant expansion
    localparam idx_t COF_COL0 [3] = '{4'd0, 4'd3, 4'd6};

endpackage

// ===== design/m3i_cofactor.sv =====
module m3i_cofactor #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] a    [m3i_pkg::NUM_ELEMS],
    output logic signed [2*W:0] cof  [m3i_pkg::NUM_ELEMS],
    output logic signed [W-1:0] row0 [3]
);

    logic signed [2*W-1:0] prod_p_reg [m3i_pkg::NUM_ELEMS];
    logic signed [2*W-1:0] prod_q_reg [m3i_pkg::NUM_ELEMS];
    logic signed [2*W:0]   cof_reg    [m3i_pkg::NUM_ELEMS];
    logic signed [W-1:0]   row0_s1_reg [3];
    logic signed [W-1:0]   row0_s2_reg [3];

    // stage 1: the two products of each cofactor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
            begin
                prod_p_reg[k] <= a[m3i_pkg::PROD_A_IDX[k]] * a[m3i_pkg::PROD_B_IDX[k]];
                prod_q_reg[k] <= a[m3i_pkg::SUBT_A_IDX[k]] * a[m3i_pkg::SUBT_B_IDX[k]];
            end
            for (int j = 0; j < 3; j++)
            begin
                row0_s1_reg[j] <= a[j];
            end
        end
    end

    // stage 2: exact difference
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
            begin
                cof_reg[k] <= (2*W+1)'(prod_p_reg[k]) - (2*W+1)'(prod_q_reg[k]);
            end
            row0_s2_reg <= row0_s1_reg;
        end
    end

    assign cof  = cof_reg;
    assign row0 = row0_s2_reg;

endmodule

// ===== design/m3i_det.sv =====
module m3i_det #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   a0  [3],
    input  logic signed [2*W:0]   c0  [3],
    output logic signed [3*W+2:0] det
);

    logic signed [2*W:0]   lo_reg   [3];
    logic signed [2*W:0]   hi_reg   [3];
    logic signed [3*W:0]   term_reg [3];
    logic signed [3*W+2:0] det_reg;

    // stage 1: multiply row 0 by an unsigned low half and a signed high part of each cofactor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lo_reg[j] <= a0[j] * $signed({1'b0, c0[j][W-1:0]});
                hi_reg[j] <= a0[j] * $signed(c0[j][2*W:W]);
            end
        end
    end

    // stage 2: recombine partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                term_reg[j] <= ((3*W+1)'(hi_reg[j]) <<< W) + (3*W+1)'(lo_reg[j]);
            end
        end
    end

    // stage 3: row 0 expansion
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= (3*W+3)'(term_reg[0]) + (3*W+3)'(term_reg[1])
                     + (3*W+3)'(term_reg[2]);
        end
    end

    assign det = det_reg;

endmodule

// ===== design/m3i_div.sv =====
module m3i_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [2*W:0]   num,
    input  logic signed [3*W+2:0] den,
    output logic signed [W-1:0]   quot,
    output logic                  sat
);

    localparam int NW = 2*W + 1 + 2*F;
    localparam int DW = 3*W + 3;
    localparam int QW = W + 1;
    localparam int RW = (NW > DW + W + 2) ? NW : DW + W + 2;

    logic signed [NW-1:0] n_ext;
    logic [NW-1:0]        n_mag;
    logic [DW-1:0]        d_mag;

    logic [RW-1:0] rem_reg  [0:QW-1];
    logic [DW-1:0] dmag_reg [0:QW-1];
    logic [QW-1:0] quo_reg  [0:QW];
    logic          neg_reg  [0:QW];
    logic          ovf_reg  [0:QW];

    logic [QW-1:0]       lim_pos;
    logic [QW-1:0]       lim_neg;
    logic [QW-1:0]       q_fin;
    logic [QW-1:0]       q_neg;
    logic                over;
    logic signed [W-1:0] quot_next;
    logic signed [W-1:0] quot_reg;
    logic                sat_reg;

    assign n_ext = NW'(num) <<< (2*F);
    assign n_mag = n_ext[NW-1] ? NW'(-n_ext) : NW'(n_ext);
    assign d_mag = den[DW-1] ? DW'(-den) : DW'(den);

    // prep stage: magnitudes, sign and quotient range check
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= RW'(n_mag);
            dmag_reg[0] <= d_mag;
            quo_reg[0]  <= '0;
            neg_reg[0]  <= n_ext[NW-1] ^ den[DW-1];
            ovf_reg[0]  <= RW'(n_mag) >= (RW'(d_mag) << QW);
        end
    end

    // one restoring step per stage, msb first
    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [RW-1:0] trial;
        logic          take;

        assign trial = RW'(dmag_reg[k-1]) << (QW - k);
        assign take  = rem_reg[k-1] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], take};
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k < QW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= take ? rem_reg[k-1] - trial : rem_reg[k-1];
                    dmag_reg[k] <= dmag_reg[k-1];
                end
            end
        end
    end

    // sign and clip
    assign lim_pos = QW'({(W-1){1'b1}});
    assign lim_neg = QW'(1) << (W - 1);
    assign q_fin   = quo_reg[QW];
    assign q_neg   = -q_fin;
    assign over    = ovf_reg[QW] || (neg_reg[QW] ? (q_fin > lim_neg) : (q_fin > lim_pos));

    always_comb
    begin
        if (over)
        begin
            quot_next = neg_reg[QW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            quot_next = neg_reg[QW] ? q_neg[W-1:0] : q_fin[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
            sat_reg  <= over;
        end
    end

    assign quot = quot_reg;
    assign sat  = sat_reg;

endmodule

// ===== design/matrix3_inverse.sv =====
// 3x3 matrix inverse by the adjugate, signed fixed point with FRAC_BITS fraction bits.
// One matrix beat is taken on every cycle that src_stall is low, and the inverse comes
// out at the end of the pipeline; the throughput is one matrix per cycle while src_stall
// stays low. The pipeline is the nine divider lanes, which resolve one quotient bit per
// register stage, plus two cofactor stages, three determinant stages, and a prep stage
// and a clip stage in each lane. Inverse elements are cofactor * 2^(2F) /
// det, truncated toward zero and saturated; determinant is det / 2^(2F) the same way.
// A singular matrix gives all zeros with invertible and saturated low. Back-pressure
// freezes the whole pipeline: src_stall is high exactly while a finished beat waits
// at the output under dst_stall.
module matrix3_inverse #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         src_valid,
    output logic                         src_stall,
    input  logic signed [ELEM_WIDTH-1:0] m00,
    input  logic signed [ELEM_WIDTH-1:0] m01,
    input  logic signed [ELEM_WIDTH-1:0] m02,
    input  logic signed [ELEM_WIDTH-1:0] m10,
    input  logic signed [ELEM_WIDTH-1:0] m11,
    input  logic signed [ELEM_WIDTH-1:0] m12,
    input  logic signed [ELEM_WIDTH-1:0] m20,
    input  logic signed [ELEM_WIDTH-1:0] m21,
    input  logic signed [ELEM_WIDTH-1:0] m22,

    output logic                         dst_valid,
    input  logic                         dst_stall,
    output logic signed [ELEM_WIDTH-1:0] i00,
    output logic signed [ELEM_WIDTH-1:0] i01,
    output logic signed [ELEM_WIDTH-1:0] i02,
    output logic signed [ELEM_WIDTH-1:0] i10,
    output logic signed [ELEM_WIDTH-1:0] i11,
    output logic signed [ELEM_WIDTH-1:0] i12,
    output logic signed [ELEM_WIDTH-1:0] i20,
    output logic signed [ELEM_WIDTH-1:0] i21,
    output logic signed [ELEM_WIDTH-1:0] i22,
    output logic signed [ELEM_WIDTH-1:0] determinant,
    output logic                         invertible,
    output logic                         saturated
);

    localparam int W   = ELEM_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 3*W + 3;      // exact determinant width
    localparam int DLY = W + 3;        // depth of the divider lane pipeline
    localparam int LAT = W + 8;        // pipeline depth, input to output

    // pipeline enable: everything moves unless the output beat is held
    logic en;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    logic signed [W-1:0]  elem    [m3i_pkg::NUM_ELEMS];
    logic signed [2*W:0]  cof     [m3i_pkg::NUM_ELEMS];
    logic signed [W-1:0]  row0    [3];
    logic signed [2*W:0]  col0    [3];
    logic signed [DW-1:0] det_w;

    // cofactors wait here for the determinant
    logic signed [2*W:0] cof_dly_reg [0:2][m3i_pkg::NUM_ELEMS];

    logic signed [W-1:0] lane_quot [m3i_pkg::NUM_ELEMS];
    logic [m3i_pkg::NUM_ELEMS-1:0] lane_sat;

    // determinant output path
    logic          d_zero;
    logic          d_neg;
    logic [DW-1:0] d_mag;
    logic [DW-1:0] d_shr;
    logic [DW-1:0] d_shr_neg;
    logic          d_over;
    logic signed [W-1:0] d_val;

    logic signed [W-1:0] dval_reg  [0:DLY-1];
    logic                dsat_reg  [0:DLY-1];
    logic                dzero_reg [0:DLY-1];

    logic zero_f;

    assign en        = !(vld_reg[LAT-1] && dst_stall);
    assign src_stall = !en;
    assign dst_valid = vld_reg[LAT-1];

    // valid bits travel alongside the data
    assign vld_next = {vld_reg[LAT-2:0], src_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign elem[0] = m00;
    assign elem[1] = m01;
    assign elem[2] = m02;
    assign elem[3] = m10;
    assign elem[4] = m11;
    assign elem[5] = m12;
    assign elem[6] = m20;
    assign elem[7] = m21;
    assign elem[8] = m22;

    // two stages: products, then exact cofactors
    m3i_cofactor #(
        .W (W)
    ) u_cofactor (
        .clk  (clk),
        .en   (en),
        .a    (elem),
        .cof  (cof),
        .row0 (row0)
    );

    for (genvar j = 0; j < 3; j++)
    begin : g_col0
        assign col0[j] = cof[m3i_pkg::COF_COL0[j]];
    end

    // three stages: split products, recombine, sum
    m3i_det #(
        .W (W)
    ) u_det (
        .clk (clk),
        .en  (en),
        .a0  (row0),
        .c0  (col0),
        .det (det_w)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cof_dly_reg[0] <= cof;
            cof_dly_reg[1] <= cof_dly_reg[0];
            cof_dly_reg[2] <= cof_dly_reg[1];
        end
    end

    // nine dividers side by side, one per inverse element
    for (genvar k = 0; k < m3i_pkg::NUM_ELEMS; k++)
    begin : g_lane
        m3i_div #(
            .W (W),
            .F (F)
        ) u_div (
            .clk  (clk),
            .en   (en),
            .num  (cof_dly_reg[2][k]),
            .den  (det_w),
            .quot (lane_quot[k]),
            .sat  (lane_sat[k])
        );
    end

    // determinant scaled back to the q format, truncated toward zero
    assign d_zero    = (det_w == '0);
    assign d_neg     = det_w[DW-1];
    assign d_mag     = d_neg ? DW'(-det_w) : DW'(det_w);
    assign d_shr     = d_mag >> (2*F);
    assign d_shr_neg = -d_shr;
    assign d_over    = d_neg ? (d_shr > (DW'(1) << (W - 1))) : (d_shr > DW'({(W-1){1'b1}}));

    always_comb
    begin
        if (d_over)
        begin
            d_val = d_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            d_val = d_neg ? d_shr_neg[W-1:0] : d_shr[W-1:0];
        end
    end

    // hold the determinant result until the lanes catch up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dval_reg[0]  <= d_val;
            dsat_reg[0]  <= d_over;
            dzero_reg[0] <= d_zero;
            for (int s = 1; s < DLY; s++)
            begin
                dval_reg[s]  <= dval_reg[s-1];
                dsat_reg[s]  <= dsat_reg[s-1];
                dzero_reg[s] <= dzero_reg[s-1];
            end
        end
    end

    // singular matrix forces zeros
    assign zero_f      = dzero_reg[DLY-1];
    assign i00         = zero_f ? '0 : lane_quot[0];
    assign i01         = zero_f ? '0 : lane_quot[1];
    assign i02         = zero_f ? '0 : lane_quot[2];
    assign i10         = zero_f ? '0 : lane_quot[3];
    assign i11         = zero_f ? '0 : lane_quot[4];
    assign i12         = zero_f ? '0 : lane_quot[5];
    assign i20         = zero_f ? '0 : lane_quot[6];
    assign i21         = zero_f ? '0 : lane_quot[7];
    assign i22         = zero_f ? '0 : lane_quot[8];
    assign determinant = zero_f ? '0 : dval_reg[DLY-1];
    assign invertible  = !zero_f;
    assign saturated   = !zero_f && ((|lane_sat) || dsat_reg[DLY-1]);

    // input back-pressure only comes from a held output beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> (dst_valid && dst_stall))
        else $error("src_stall without a held output beat");

    // a frozen pipeline keeps its valid bits
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved while frozen");

    // an accepted beat lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall) |=> vld_reg[0])
        else $error("accepted beat lost at entry");

    // singular result has zero determinant and diagonal and is unflagged
    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !invertible) |->
            (!saturated && determinant == '0 && i00 == '0 && i11 == '0 && i22 == '0))
        else $error("singular result not cleared");

endmodule

// ===== sim/matrix3_inverse_test.sv =====
`timescale 1ns / 100ps

module matrix3_inverse_test;

    localparam int EW = 32;
    localparam int FB = 16;
    localparam int LATENCY = EW + 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 1900;

    // the result one matrix should produce
    typedef struct {
        logic signed [EW-1:0] inv [m3i_pkg::NUM_ELEMS];
        logic signed [EW-1:0] det;
        logic                 ok;
        logic                 sat;
    } inverse_t;

    typedef logic signed [EW-1:0] matrix_t [m3i_pkg::NUM_ELEMS];

    // directed row: matrix plus an optional typed-in answer
    typedef struct {
        matrix_t  mat;
        logic     has_answer;
        inverse_t answer;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic src_valid;
    logic src_stall;
    logic signed [EW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic dst_valid;
    logic dst_stall;
    logic signed [EW-1:0] i00, i01, i02, i10, i11, i12, i20, i21, i22;
    logic signed [EW-1:0] determinant;
    logic invertible;
    logic saturated;

    inverse_t pending_inverses[$];
    int       error_count;
    int       cycle_count;
    bit       quiet_phase;
    bit       stim_done;

    matrix3_inverse #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) uut (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22),
        .dst_valid(dst_valid), .dst_stall(dst_stall),
        .i00(i00), .i01(i01), .i02(i02), .i10(i10), .i11(i11), .i12(i12),
        .i20(i20), .i21(i21), .i22(i22),
        .determinant(determinant), .invertible(invertible), .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // clip a wide signed value to EW bits, flagging any overflow
    function automatic logic signed [EW-1:0] clip_elem(input logic signed [255:0] v,
                                                       inout logic sat);
        logic signed [255:0] hi;
        logic signed [255:0] lo;
        hi = (256'sd1 <<< (EW - 1)) - 1;
        lo = -(256'sd1 <<< (EW - 1));
        if (v > hi)
        begin
            sat = 1'b1;
            return hi[EW-1:0];
        end
        if (v < lo)
        begin
            sat = 1'b1;
            return lo[EW-1:0];
        end
        return v[EW-1:0];
    endfunction

    // exact adjugate inverse; sv division truncates toward zero like the design
    function automatic inverse_t invert_matrix(input matrix_t m);
        inverse_t r;
        logic signed [255:0] a [m3i_pkg::NUM_ELEMS];
        logic signed [255:0] cof [m3i_pkg::NUM_ELEMS];
        logic signed [255:0] dt;
        logic sat;
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
            a[k] = 256'(m[k]);
        cof[0] = a[4]*a[8] - a[5]*a[7];
        cof[1] = a[2]*a[7] - a[1]*a[8];
        cof[2] = a[1]*a[5] - a[2]*a[4];
        cof[3] = a[5]*a[6] - a[3]*a[8];
        cof[4] = a[0]*a[8] - a[2]*a[6];
        cof[5] = a[2]*a[3] - a[0]*a[5];
        cof[6] = a[3]*a[7] - a[4]*a[6];
        cof[7] = a[1]*a[6] - a[0]*a[7];
        cof[8] = a[0]*a[4] - a[1]*a[3];
        dt = a[0]*cof[0] + a[1]*cof[3] + a[2]*cof[6];
        sat = 1'b0;
        if (dt == 0)
        begin
            for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
                r.inv[k] = '0;
            r.det = '0;
            r.ok = 1'b0;
            r.sat = 1'b0;
            return r;
        end
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
            r.inv[k] = clip_elem((cof[k] <<< (2 * FB)) / dt, sat);
        r.det = clip_elem(dt / (256'sd1 <<< (2 * FB)), sat);
        r.ok = 1'b1;
        r.sat = sat;
        return r;
    endfunction

    // random element: mostly moderate values, sometimes extremes or full range
    function automatic logic signed [EW-1:0] random_elem();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return 32'($signed($urandom_range(0, 8)) - 4) <<< FB;
            3: return 32'($signed($urandom_range(0, 511)) - 256);
            default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t m;
        int kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
            m[k] = random_elem();
        // singular: copy one row onto another, or scale it
        if (kind == 0)
            for (int c = 0; c < 3; c++)
                m[3 + c] = m[c];
        else if (kind == 1)
            for (int c = 0; c < 3; c++)
                m[6 + c] = -m[c];
        return m;
    endfunction

    function automatic stim_row_t row_open(input matrix_t m);
        stim_row_t s;
        s.mat = m;
        s.has_answer = 1'b0;
        return s;
    endfunction

    function automatic stim_row_t row_fixed(input matrix_t m, input inverse_t ans);
        stim_row_t s;
        s.mat = m;
        s.has_answer = 1'b1;
        s.answer = ans;
        return s;
    endfunction

    // drive one beat at the falling edge, sometimes after an idle gap, and hold it until accepted
    task automatic send_matrix(input matrix_t m, input inverse_t want);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        src_valid <= 1'b1;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
            {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        pending_inverses.push_back(want);
        @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        stim_row_t table_rows[$];
        matrix_t   m;
        inverse_t  zero_ans;
        inverse_t  unit_ans;
        inverse_t  sat_ans;
        src_valid = 1'b0;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
        rst_n = 1'b0;
        quiet_phase = 1'b0;
        stim_done = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // singular all-zero matrix reads back all zeros
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
        begin
            m[k] = '0;
            zero_ans.inv[k] = '0;
            unit_ans.inv[k] = (k % 4 == 0) ? 32'sh0001_0000 : '0;
        end
        zero_ans.det = '0; zero_ans.ok = 1'b0; zero_ans.sat = 1'b0;
        table_rows.push_back(row_fixed(m, zero_ans));
        // identity inverts to itself
        unit_ans.det = 32'sh0001_0000; unit_ans.ok = 1'b1; unit_ans.sat = 1'b0;
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
            m[k] = (k % 4 == 0) ? 32'sh0001_0000 : '0;
        table_rows.push_back(row_fixed(m, unit_ans));
        // tiny diagonal: determinant truncates to zero, inverse saturates
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
        begin
            m[k] = (k % 4 == 0) ? 32'sd1 : '0;
            sat_ans.inv[k] = (k % 4 == 0) ? 32'sh7fffffff : '0;
        end
        sat_ans.det = '0; sat_ans.ok = 1'b1; sat_ans.sat = 1'b1;
        table_rows.push_back(row_fixed(m, sat_ans));
        // negative tiny diagonal saturates low
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
        begin
            m[k] = (k % 4 == 0) ? -32'sd1 : '0;
            sat_ans.inv[k] = (k % 4 == 0) ? 32'sh80000000 : '0;
        end
        table_rows.push_back(row_fixed(m, sat_ans));
        // extremes on the diagonal, huge determinant
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
            m[k] = (k % 4 == 0) ? 32'sh80000000 : '0;
        table_rows.push_back(row_open(m));
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
            m[k] = (k % 4 == 0) ? 32'sh7fffffff : '0;
        table_rows.push_back(row_open(m));
        // all ones bits and all max: singular
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
            m[k] = 32'sh7fffffff;
        table_rows.push_back(row_fixed(m, zero_ans));
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
            m[k] = -32'sd1;
        table_rows.push_back(row_fixed(m, zero_ans));
        // alternating extremes
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
            m[k] = (k % 2) ? 32'sh80000000 : 32'sh7fffffff;
        table_rows.push_back(row_open(m));
        // a permutation matrix and a general fractional matrix
        m = '{0, 32'sh10000, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
        table_rows.push_back(row_open(m));
        m = '{32'sh20000, 32'sh10000, 0, 0, -32'sh30000, 32'sh8000, 32'sh4000, 0, 32'sh18000};
        table_rows.push_back(row_open(m));
        for (int n = 0; n < 10; n++)
            table_rows.push_back(row_open(random_matrix()));

        foreach (table_rows[r])
            send_matrix(table_rows[r].mat, table_rows[r].has_answer ?
                        table_rows[r].answer : invert_matrix(table_rows[r].mat));

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS - 300)
                quiet_phase = 1'b1;
            m = random_matrix();
            send_matrix(m, invert_matrix(m));
        end
        src_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // output side: random stall bursts, none in the quiet phase
    initial
    begin
        int burst;
        dst_stall = 1'b0;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
                burst--;
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 5);
            dst_stall <= (burst > 0);
        end
    end

    // compare each result beat against the oldest expectation
    always @(posedge clk)
    begin
        inverse_t want;
        logic signed [EW-1:0] got [m3i_pkg::NUM_ELEMS];
        if (rst_n && dst_valid && !dst_stall)
        begin
            got = '{i00, i01, i02, i10, i11, i12, i20, i21, i22};
            if (pending_inverses.size() == 0)
            begin
                $error("result beat with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_inverses.pop_front();
                for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
                    if (got[k] !== want.inv[k])
                    begin
                        $error("i%0d%0d: expected %0d, got %0d", k / 3, k % 3,
                               want.inv[k], got[k]);
                        error_count++;
                    end
                if (determinant !== want.det)
                begin
                    $error("determinant: expected %0d, got %0d", want.det, determinant);
                    error_count++;
                end
                if (invertible !== want.ok)
                begin
                    $error("invertible: expected %0d, got %0d", want.ok, invertible);
                    error_count++;
                end
                if (saturated !== want.sat)
                begin
                    $error("saturated: expected %0d, got %0d", want.sat, saturated);
                    error_count++;
                end
            end
        end
    end

    // end of run and timeout
    initial
    begin
        error_count = 0;
        cycle_count = 0;
        while (!(stim_done && pending_inverses.size() == 0) && cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            // drain: catch any stray beats after the last expected one
            repeat (2 * LATENCY) @(posedge clk);
            if (error_count == 0)
                $display("end of test: clean");
            else
                $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
